// File: rtl/core/kabf_pkg.sv
package kabf_pkg;

    // Field widths fixed by the block's formats.
    localparam int ANGLE_W = 32;
    localparam int DT_W = 24;
    localparam int NOISE_W = 31;
    localparam int CFG_IDX_W = 2;
    localparam int DT_FRAC_BITS = 24;

    // Default fixed point formats.
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int COV_FRAC_BITS_DEF = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_BIAS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_MEAS = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } state_t;

    // Datapath operations in the order they are run for one request.
    typedef enum logic [3:0] {
        OP_ANGLE_PRED,
        OP_CROSS,
        OP_P00_PRED,
        OP_P11_PRED,
        OP_GAIN0,
        OP_GAIN1,
        OP_BIAS_COR,
        OP_ANGLE_COR,
        OP_C00,
        OP_C01,
        OP_C10,
        OP_C11
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        op_t  op;
        logic publish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
    } status_t;

    // True for the operations that run on the divider.
    function automatic logic is_div(input op_t op);
        return (op == OP_GAIN0) || (op == OP_GAIN1);
    endfunction

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        logic signed [79:0] hi;
        logic signed [79:0] lo;
        hi = 80'sh7FFFFFFF;
        lo = -80'sh80000000;
        if (v > hi)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < lo)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// File: rtl/core/kabf_if.sv
// Input channel: one measurement request.
interface kabf_in_if;
    logic valid;
    logic ready;
    logic signed [kabf_pkg::ANGLE_W-1:0] measured_angle;
    logic signed [kabf_pkg::ANGLE_W-1:0] gyro_rate;
    logic [kabf_pkg::DT_W-1:0] time_step;

    modport source(output valid, output measured_angle, output gyro_rate,
                   output time_step, input ready);
    modport sink(input valid, input measured_angle, input gyro_rate,
                 input time_step, output ready);
endinterface

// Output channel: one filtered estimate.
interface kabf_out_if;
    logic valid;
    logic ready;
    logic signed [kabf_pkg::ANGLE_W-1:0] angle_estimate;
    logic signed [kabf_pkg::ANGLE_W-1:0] bias_estimate;

    modport source(output valid, output angle_estimate, output bias_estimate,
                   input ready);
    modport sink(input valid, input angle_estimate, input bias_estimate,
                 output ready);
endinterface

// File: rtl/core/kabf_divider.sv
// Signed restoring divider for the gains: (num * 2^C) / den, truncated
// toward zero and saturated to 32 bits. A zero divisor gives zero.
module kabf_divider #(
    parameter int COV_FRAC_BITS = kabf_pkg::COV_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [33:0] den,
    output logic               done,
    output logic signed [31:0] quo
);
    localparam int NUM_W = 32 + COV_FRAC_BITS;
    localparam int DEN_W = 34;
    localparam int REM_W = DEN_W + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] dmag_reg, dmag_next;
    logic             neg_reg, neg_next;
    logic             zero_reg, zero_next;

    logic [31:0]      nmag;
    logic [DEN_W-1:0] dmag;
    logic [REM_W-1:0] rem_sh;
    logic             fits;

    // Operand magnitudes and one restoring step.
    always_comb
    begin
        nmag = num[31] ? (~num + 32'd1) : num;
        dmag = den[DEN_W-1] ? (~den + 34'd1) : den;
        rem_sh = {rem_reg[REM_W-2:0], quo_reg[NUM_W-1]};
        fits = rem_sh >= {1'b0, dmag_reg};
    end

    // Iteration control, one quotient bit a cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dmag_next = dmag_reg;
        neg_next = neg_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(NUM_W);
            quo_next = {nmag, {COV_FRAC_BITS{1'b0}}};
            rem_next = '0;
            dmag_next = dmag;
            neg_next = num[31] ^ den[DEN_W-1];
            zero_next = (den == '0);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg <= neg_next;
        zero_reg <= zero_next;
    end

    // Apply the sign and saturate.
    always_comb
    begin
        if (zero_reg)
        begin
            quo = '0;
        end
        else if (neg_reg)
        begin
            if (quo_reg > NUM_W'(33'h080000000))
            begin
                quo = 32'sh80000000;
            end
            else
            begin
                quo = ~quo_reg[31:0] + 32'd1;
            end
        end
        else
        begin
            if (quo_reg > NUM_W'(32'h7FFFFFFF))
            begin
                quo = 32'sh7FFFFFFF;
            end
            else
            begin
                quo = quo_reg[31:0];
            end
        end
    end

    assign done = done_reg;

endmodule

// File: rtl/core/kabf_datapath.sv
// Filter state, noise registers, a two-pass 36x18 multiplier and the gain
// divider. Each operation writes its result back when the unit finishes.
module kabf_datapath #(
    parameter int ANGLE_FRAC_BITS = kabf_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int COV_FRAC_BITS = kabf_pkg::COV_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [kabf_pkg::ANGLE_W-1:0]    measured_angle,
    input  logic signed [kabf_pkg::ANGLE_W-1:0]    gyro_rate,
    input  logic [kabf_pkg::DT_W-1:0]              time_step,
    input  logic                                   cfg_we,
    input  logic [kabf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [kabf_pkg::NOISE_W-1:0]           cfg_data,
    input  kabf_pkg::cmd_t                         cmd,
    output kabf_pkg::status_t                      status,
    output logic signed [kabf_pkg::ANGLE_W-1:0]    angle_estimate,
    output logic signed [kabf_pkg::ANGLE_W-1:0]    bias_estimate
);
    localparam logic [63:0] QA_RST = ((64'd1 << COV_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [63:0] QB_RST = ((64'd3 << COV_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [63:0] R_RST = ((64'd30 << COV_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [63:0] BIAS_RST = ((64'd3 << ANGLE_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic signed [71:0] HALF_DT = 72'sd1 <<< (kabf_pkg::DT_FRAC_BITS - 1);
    localparam logic signed [71:0] HALF_COV = 72'sd1 <<< (COV_FRAC_BITS - 1);

    // Noise registers.
    logic [30:0] qa_reg, qb_reg, r_reg;

    // Filter state and per-request working values.
    logic signed [31:0] ang_reg, ang_next;
    logic signed [31:0] bia_reg, bia_next;
    logic signed [31:0] p00_reg, p00_next, p01_reg, p01_next;
    logic signed [31:0] p10_reg, p10_next, p11_reg, p11_next;
    logic signed [31:0] n00_reg, n00_next, n01_reg, n01_next;
    logic signed [31:0] n10_reg, n10_next, n11_reg, n11_next;
    logic signed [31:0] k0_reg, k0_next, k1_reg, k1_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] meas_reg, meas_next;
    logic signed [32:0] rate_reg, rate_next;
    logic [23:0]        dt_reg, dt_next;
    logic signed [35:0] inner_reg, inner_next;
    logic signed [31:0] out_ang_reg, out_bia_reg;

    // Multiplier.
    logic signed [35:0] mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic signed [71:0] acc_reg, acc_next;
    logic [1:0]         mcnt_reg, mcnt_next;
    logic               mul_done;
    logic signed [71:0] rnd_dt, rnd_cov;

    // Divider hookup.
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_quo;
    logic signed [33:0] div_den;
    logic signed [31:0] qa_s, qb_s;
    logic signed [35:0] dt_s;

    assign qa_s = $signed({1'b0, qa_reg});
    assign qb_s = $signed({1'b0, qb_reg});
    assign dt_s = $signed({12'd0, dt_reg});
    assign mul_done = (mcnt_reg == 2'd3);
    assign rnd_dt = (acc_reg + HALF_DT) >>> kabf_pkg::DT_FRAC_BITS;
    assign rnd_cov = (acc_reg + HALF_COV) >>> COV_FRAC_BITS;

    assign div_start = cmd.start && kabf_pkg::is_div(cmd.op);
    assign div_num = (cmd.op == kabf_pkg::OP_GAIN0) ? n00_reg : n10_reg;
    assign div_den = 34'(n00_reg) + 34'($signed({1'b0, r_reg}));

    kabf_divider #(
        .COV_FRAC_BITS(COV_FRAC_BITS)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .num(div_num),
        .den(div_den),
        .done(div_done),
        .quo(div_quo)
    );

    assign status.done = mul_done || div_done;

    // Multiplier sequencing: low half, then high half of the b operand.
    always_comb
    begin
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        acc_next = acc_reg;
        mcnt_next = mcnt_reg;
        if (cmd.start && !kabf_pkg::is_div(cmd.op))
        begin
            mcnt_next = 2'd1;
            case (cmd.op)
                kabf_pkg::OP_ANGLE_PRED: begin mul_a_next = dt_s; mul_b_next = 36'(rate_reg); end
                kabf_pkg::OP_CROSS:      begin mul_a_next = dt_s; mul_b_next = 36'(p11_reg); end
                kabf_pkg::OP_P00_PRED:   begin mul_a_next = dt_s; mul_b_next = inner_reg; end
                kabf_pkg::OP_P11_PRED:   begin mul_a_next = 36'(qb_s); mul_b_next = dt_s; end
                kabf_pkg::OP_BIAS_COR:   begin mul_a_next = 36'(k1_reg); mul_b_next = 36'(y_reg); end
                kabf_pkg::OP_ANGLE_COR:  begin mul_a_next = 36'(k0_reg); mul_b_next = 36'(y_reg); end
                kabf_pkg::OP_C00:        begin mul_a_next = 36'(k0_reg); mul_b_next = 36'(n00_reg); end
                kabf_pkg::OP_C01:        begin mul_a_next = 36'(k0_reg); mul_b_next = 36'(n01_reg); end
                kabf_pkg::OP_C10:        begin mul_a_next = 36'(k1_reg); mul_b_next = 36'(n00_reg); end
                kabf_pkg::OP_C11:        begin mul_a_next = 36'(k1_reg); mul_b_next = 36'(n01_reg); end
                default:                 begin mul_a_next = '0; mul_b_next = '0; end
            endcase
        end
        else
        begin
            case (mcnt_reg)
                2'd1:
                begin
                    acc_next = mul_a_reg * $signed({1'b0, mul_b_reg[17:0]});
                    mcnt_next = 2'd2;
                end
                2'd2:
                begin
                    // The upper half carries the sign of the b operand.
                    acc_next = acc_reg + ((mul_a_reg * $signed(mul_b_reg[35:18])) <<< 18);
                    mcnt_next = 2'd3;
                end
                2'd3:
                begin
                    mcnt_next = 2'd0;
                end
                default:
                begin
                    mcnt_next = 2'd0;
                end
            endcase
        end
    end

    // Request capture and result write-back.
    always_comb
    begin
        ang_next = ang_reg;
        bia_next = bia_reg;
        p00_next = p00_reg;
        p01_next = p01_reg;
        p10_next = p10_reg;
        p11_next = p11_reg;
        n00_next = n00_reg;
        n01_next = n01_reg;
        n10_next = n10_reg;
        n11_next = n11_reg;
        k0_next = k0_reg;
        k1_next = k1_reg;
        y_next = y_reg;
        meas_next = meas_reg;
        rate_next = rate_reg;
        dt_next = dt_reg;
        inner_next = inner_reg;
        if (cmd.load)
        begin
            meas_next = measured_angle;
            rate_next = 33'(gyro_rate) - 33'(bia_reg);
            dt_next = time_step;
        end
        if (mul_done)
        begin
            case (cmd.op)
                kabf_pkg::OP_ANGLE_PRED:
                begin
                    ang_next = kabf_pkg::sat32(80'(ang_reg) + 80'(rnd_dt));
                end
                kabf_pkg::OP_CROSS:
                begin
                    n01_next = kabf_pkg::sat32(80'(p01_reg) - 80'(rnd_dt));
                    n10_next = kabf_pkg::sat32(80'(p10_reg) - 80'(rnd_dt));
                    inner_next = 36'(rnd_dt) - 36'(p01_reg) - 36'(p10_reg) + 36'(qa_s);
                end
                kabf_pkg::OP_P00_PRED:
                begin
                    n00_next = kabf_pkg::sat32(80'(p00_reg) + 80'(rnd_dt));
                end
                kabf_pkg::OP_P11_PRED:
                begin
                    n11_next = kabf_pkg::sat32(80'(p11_reg) + 80'(rnd_dt));
                    y_next = kabf_pkg::sat32(80'(meas_reg) - 80'(ang_reg));
                end
                kabf_pkg::OP_BIAS_COR:
                begin
                    bia_next = kabf_pkg::sat32(80'(bia_reg) + 80'(rnd_cov));
                end
                kabf_pkg::OP_ANGLE_COR:
                begin
                    ang_next = kabf_pkg::sat32(80'(ang_reg) + 80'(rnd_cov));
                end
                kabf_pkg::OP_C00:
                begin
                    p00_next = kabf_pkg::sat32(80'(n00_reg) - 80'(rnd_cov));
                end
                kabf_pkg::OP_C01:
                begin
                    p01_next = kabf_pkg::sat32(80'(n01_reg) - 80'(rnd_cov));
                end
                kabf_pkg::OP_C10:
                begin
                    p10_next = kabf_pkg::sat32(80'(n10_reg) - 80'(rnd_cov));
                end
                kabf_pkg::OP_C11:
                begin
                    p11_next = kabf_pkg::sat32(80'(n11_reg) - 80'(rnd_cov));
                end
                default:
                begin
                    ang_next = ang_reg;
                end
            endcase
        end
        if (div_done)
        begin
            if (cmd.op == kabf_pkg::OP_GAIN0)
            begin
                k0_next = div_quo;
            end
            else
            begin
                k1_next = div_quo;
            end
        end
    end

    // Filter state and noise registers come out of reset with defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= QA_RST[30:0];
            qb_reg <= QB_RST[30:0];
            r_reg <= R_RST[30:0];
            ang_reg <= '0;
            bia_reg <= BIAS_RST[31:0];
            p00_reg <= '0;
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= '0;
            mcnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    kabf_pkg::CFG_NOISE_ANGLE: qa_reg <= cfg_data;
                    kabf_pkg::CFG_NOISE_BIAS:  qb_reg <= cfg_data;
                    kabf_pkg::CFG_NOISE_MEAS:  r_reg <= cfg_data;
                    default:                   qa_reg <= qa_reg;
                endcase
            end
            ang_reg <= ang_next;
            bia_reg <= bia_next;
            p00_reg <= p00_next;
            p01_reg <= p01_next;
            p10_reg <= p10_next;
            p11_reg <= p11_next;
            mcnt_reg <= mcnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        n00_reg <= n00_next;
        n01_reg <= n01_next;
        n10_reg <= n10_next;
        n11_reg <= n11_next;
        k0_reg <= k0_next;
        k1_reg <= k1_next;
        y_reg <= y_next;
        meas_reg <= meas_next;
        rate_reg <= rate_next;
        dt_reg <= dt_next;
        inner_reg <= inner_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        acc_reg <= acc_next;
        if (cmd.publish)
        begin
            out_ang_reg <= ang_reg;
            out_bia_reg <= bia_reg;
        end
    end

    assign angle_estimate = out_ang_reg;
    assign bias_estimate = out_bia_reg;

endmodule

// File: rtl/core/kabf_controller.sv
// Sequencer: takes a request, runs the operation list one unit at a time,
// then hands the result to the output register.
module kabf_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    input  kabf_pkg::status_t status,
    output kabf_pkg::cmd_t    cmd
);
    kabf_pkg::state_t state_reg, state_next;
    kabf_pkg::op_t    op_reg, op_next;
    logic             out_valid_reg, out_valid_next;
    logic             can_publish;

    assign can_publish = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        case (state_reg)
            kabf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = kabf_pkg::ST_ISSUE;
                    op_next = kabf_pkg::OP_ANGLE_PRED;
                end
            end
            kabf_pkg::ST_ISSUE:
            begin
                state_next = kabf_pkg::ST_WAIT;
            end
            kabf_pkg::ST_WAIT:
            begin
                if (status.done)
                begin
                    if (op_reg == kabf_pkg::OP_C11)
                    begin
                        state_next = kabf_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = kabf_pkg::ST_ISSUE;
                        op_next = kabf_pkg::op_t'(op_reg + 4'd1);
                    end
                end
            end
            kabf_pkg::ST_FINISH:
            begin
                if (can_publish)
                begin
                    state_next = kabf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kabf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd.load = 1'b0;
        cmd.start = 1'b0;
        cmd.op = op_reg;
        cmd.publish = 1'b0;
        in_ready = 1'b0;
        case (state_reg)
            kabf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            kabf_pkg::ST_ISSUE:
            begin
                cmd.start = 1'b1;
            end
            kabf_pkg::ST_FINISH:
            begin
                cmd.publish = can_publish;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Output valid holds until the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kabf_pkg::ST_IDLE;
            op_reg <= kabf_pkg::OP_ANGLE_PRED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/kalman_angle_bias_filter_unit.sv
// Two-state Kalman filter for tilt angle and gyro bias. Each request carries a
// measured angle and a gyro rate (signed Q16.16 by default) and a time step
// (unsigned Q0.24 seconds) and yields one result with the new angle and bias
// estimates, saturated. Covariance is signed Q8.24 and noise settings are
// unsigned Q7.24 by default; the noise registers may be written only while
// the block is idle. One request is processed at a time: ten products run on
// a two-pass 36x18 multiplier and the two gains come from a restoring divider
// at one bit a cycle. A new request is taken while the previous result still
// waits in the output register.
module kalman_angle_bias_filter_unit #(
    parameter int ANGLE_FRAC_BITS = kabf_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int COV_FRAC_BITS = kabf_pkg::COV_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    kabf_in_if.sink                        in_ch,
    kabf_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [kabf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kabf_pkg::NOISE_W-1:0]   cfg_data
);
    kabf_pkg::cmd_t    cmd;
    kabf_pkg::status_t status;

    kabf_controller u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .out_ready(out_ch.ready),
        .out_valid(out_ch.valid),
        .status(status),
        .cmd(cmd)
    );

    kabf_datapath #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .COV_FRAC_BITS(COV_FRAC_BITS)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .measured_angle(in_ch.measured_angle),
        .gyro_rate(in_ch.gyro_rate),
        .time_step(in_ch.time_step),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd(cmd),
        .status(status),
        .angle_estimate(out_ch.angle_estimate),
        .bias_estimate(out_ch.bias_estimate)
    );

endmodule
